/* rtl/core/ils_pkg.sv */
// Package for the indexed list store: operation and status codes, field widths
// and the control bundle that the top level broadcasts to every entry cell.
// No dependencies.
package ils_pkg;

    localparam int DATA_W   = 32;
    localparam int POS_W    = 6;
    localparam int OP_W     = 2;
    localparam int COUNT_W  = 7;
    localparam int STATUS_W = 2;

    localparam int DEFAULT_CAPACITY = 64;

    localparam logic [OP_W-1:0] OP_APPEND = 2'd0;
    localparam logic [OP_W-1:0] OP_READ   = 2'd1;
    localparam logic [OP_W-1:0] OP_REMOVE = 2'd2;

    localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
    localparam logic [STATUS_W-1:0] ST_FULL  = 2'd1;
    localparam logic [STATUS_W-1:0] ST_RANGE = 2'd2;

    // Broadcast to all cells in the cycle that a transaction is accepted.
    typedef struct packed {
        logic              append_en;
        logic              remove_en;
        logic [POS_W-1:0]  pos;
        logic [DATA_W-1:0] wdata;
    } t_cell_ctrl;

endpackage

/* rtl/core/ils_cell.sv */
// One entry cell of the indexed list store. Holds one element, loads it on an
// append aimed at its slot and takes its upper neighbour's element on a remove.
// Depends on ils_pkg.
module ils_cell #(
    parameter int IDX   = 0,
    parameter int CNT_W = 7
) (
    input  logic                       i_clk,
    input  logic                       i_rst_n,
    input  ils_pkg::t_cell_ctrl        i_ctrl,
    input  logic [CNT_W-1:0]           i_count,
    input  logic [ils_pkg::DATA_W-1:0] i_next,
    output logic [ils_pkg::DATA_W-1:0] o_q,
    output logic [ils_pkg::DATA_W-1:0] o_rd
);

    localparam int CW = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;
    localparam logic [CW-1:0] MY_IDX = CW'(IDX);

    logic [ils_pkg::DATA_W-1:0] r_q;
    logic                       w_write_hit;
    logic                       w_shift;
    logic                       w_sel;

    assign w_write_hit = i_ctrl.append_en && (CW'(i_count) == MY_IDX);
    assign w_shift     = i_ctrl.remove_en && (MY_IDX >= CW'(i_ctrl.pos));
    assign w_sel       = (CW'(i_ctrl.pos) == MY_IDX);

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_q <= '0;
        end else if (w_write_hit) begin
            r_q <= i_ctrl.wdata;
        end else if (w_shift) begin
            r_q <= i_next;
        end
    end

    assign o_q  = r_q;
    // Contribution to the read bus: only the addressed cell drives non-zero.
    assign o_rd = w_sel ? r_q : '0;

endmodule

/* rtl/core/indexed_list_store_unit.sv */
// Top level of the indexed list store: request decode, element count, the
// chain of entry cells and the result register.
// Depends on ils_pkg and ils_cell.
//
// Usage
// The block keeps an ordered list of up to CAPACITY signed 32-bit elements in a
// row of entry cells. A request transaction (operation, element value, position)
// arrives on the input channel; each produces exactly one result transaction
// (read value, item count, empty flag, status) on the output channel.
// Append stores the element at the end of the list, or reports the list full.
// Read returns the element at the given position. Remove returns it, and in the
// same clock every cell at or above that position takes its upper neighbour's
// element, so the list closes up and the freed top slot becomes zero.
// A position not below the count gives a range status and changes nothing.
// The result sits in the output register the cycle after the request is taken.
// Throughput is one transaction per cycle for every operation while the receiver
// does not stall, since the shift along the cell chain completes in the clock that
// takes the request; the read path is an AND-OR selection across the cells.
// When the receiver stalls, the result stays in the output register and the
// input is held off until that register is emptied or drained in the same cycle.
// Reset clears the count, every cell and the valid flag of the output register.

module indexed_list_store_unit #(
    parameter int CAPACITY = ils_pkg::DEFAULT_CAPACITY
) (
    input  logic                         i_clk,
    input  logic                         i_rst_n,
    input  logic                         i_valid,
    output logic                         o_ready,
    input  logic [ils_pkg::OP_W-1:0]     i_operation,
    input  logic signed [ils_pkg::DATA_W-1:0] i_element_value,
    input  logic [ils_pkg::POS_W-1:0]    i_position,
    output logic                         o_valid,
    input  logic                         i_ready,
    output logic signed [ils_pkg::DATA_W-1:0] o_read_value,
    output logic [ils_pkg::COUNT_W-1:0]  o_item_count,
    output logic                         o_list_empty,
    output logic [ils_pkg::STATUS_W-1:0] o_status_code
);

    localparam int CNT_W = $clog2(CAPACITY + 1);
    localparam int CW    = (CNT_W > ils_pkg::POS_W) ? CNT_W : ils_pkg::POS_W;
    localparam int EXT_W = (CNT_W > ils_pkg::COUNT_W) ? CNT_W : ils_pkg::COUNT_W;
    localparam logic [CNT_W-1:0] CAP = CNT_W'(CAPACITY);

    logic [CNT_W-1:0]           r_count;
    logic [CNT_W-1:0]           n_count;
    logic                       w_accept;
    logic                       w_full;
    logic                       w_in_range;
    logic [ils_pkg::STATUS_W-1:0] w_status;
    logic [ils_pkg::DATA_W-1:0] w_value;
    ils_pkg::t_cell_ctrl        w_ctrl;

    logic [ils_pkg::DATA_W-1:0] w_cell_q  [CAPACITY];
    logic [ils_pkg::DATA_W-1:0] w_cell_rd [CAPACITY];
    logic [ils_pkg::DATA_W-1:0] w_rd_bus;
    logic [EXT_W-1:0]           w_count_ext;

    logic                         r_out_valid;
    logic [ils_pkg::DATA_W-1:0]   r_out_value;
    logic [CNT_W-1:0]             r_out_count;
    logic [ils_pkg::STATUS_W-1:0] r_out_status;

    // The input is taken whenever the result register is free or being drained.
    assign o_ready  = !r_out_valid || i_ready;
    assign w_accept = i_valid && o_ready;

    assign w_full     = (r_count == CAP);
    assign w_in_range = (CW'(i_position) < CW'(r_count));

    // Decode: only successful appends and removes touch the cells.
    always_comb begin
        w_ctrl.append_en = 1'b0;
        w_ctrl.remove_en = 1'b0;
        w_ctrl.pos       = i_position;
        w_ctrl.wdata     = i_element_value;
        w_status         = ils_pkg::ST_OK;
        w_value          = '0;
        n_count          = r_count;
        case (i_operation)
            ils_pkg::OP_APPEND: begin
                if (w_full) begin
                    w_status = ils_pkg::ST_FULL;
                end else begin
                    w_ctrl.append_en = w_accept;
                    n_count          = r_count + CNT_W'(1);
                end
            end
            ils_pkg::OP_READ, ils_pkg::OP_REMOVE: begin
                if (!w_in_range) begin
                    w_status = ils_pkg::ST_RANGE;
                end else begin
                    w_value = w_rd_bus;
                    if (i_operation == ils_pkg::OP_REMOVE) begin
                        w_ctrl.remove_en = w_accept;
                        n_count          = r_count - CNT_W'(1);
                    end
                end
            end
            default: begin
                // Unused operation code: report the count, change nothing.
            end
        endcase
    end

    // Row of entry cells; the top cell shifts in zero so the freed slot clears.
    for (genvar g = 0; g < CAPACITY; g++) begin : g_cell
        logic [ils_pkg::DATA_W-1:0] w_next;
        if (g == CAPACITY - 1) begin : g_top
            assign w_next = '0;
        end else begin : g_mid
            assign w_next = w_cell_q[g+1];
        end
        ils_cell #(
            .IDX   (g),
            .CNT_W (CNT_W)
        ) u_cell (
            .i_clk   (i_clk),
            .i_rst_n (i_rst_n),
            .i_ctrl  (w_ctrl),
            .i_count (r_count),
            .i_next  (w_next),
            .o_q     (w_cell_q[g]),
            .o_rd    (w_cell_rd[g])
        );
    end

    // Only the addressed cell drives a non-zero contribution.
    always_comb begin
        w_rd_bus = '0;
        for (int k = 0; k < CAPACITY; k++) begin
            w_rd_bus = w_rd_bus | w_cell_rd[k];
        end
    end

    always_ff @(posedge i_clk) begin
        if (!i_rst_n) begin
            r_count     <= '0;
            r_out_valid <= 1'b0;
        end else begin
            if (w_accept) begin
                r_count     <= n_count;
                r_out_valid <= 1'b1;
            end else if (i_ready) begin
                r_out_valid <= 1'b0;
            end
        end
    end

    always_ff @(posedge i_clk) begin
        if (w_accept) begin
            r_out_value  <= w_value;
            r_out_count  <= n_count;
            r_out_status <= w_status;
        end
    end

    assign w_count_ext   = EXT_W'(r_out_count);
    assign o_valid       = r_out_valid;
    assign o_read_value  = r_out_value;
    assign o_item_count  = w_count_ext[ils_pkg::COUNT_W-1:0];
    assign o_list_empty  = (r_out_count == '0);
    assign o_status_code = r_out_status;

    // The count never passes the number of cells.
    a_count_bound: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        r_count <= CAP)
        else $error("element count beyond capacity");

    // Slots above the list hold zero, so the top cell is clear unless the list is full.
    a_top_clear: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_count != CAP) |-> (w_cell_q[CAPACITY-1] == '0))
        else $error("top cell not clear below full");

    // Every accepted request yields a result in the next cycle.
    a_result_follows: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        w_accept |=> r_out_valid)
        else $error("missing result after request");

    // A full report always comes with a non-empty list.
    a_full_not_empty: assert property (@(posedge i_clk) disable iff (!i_rst_n)
        (r_out_valid && (r_out_status == ils_pkg::ST_FULL)) |-> !o_list_empty)
        else $error("full status on an empty list");

endmodule
